// ===== rtl/core/tmhq_pkg.sv =====
// Shared types and constants for the timeout min-heap queue.
package tmhq_pkg;

  localparam int unsigned MaxTimeouts = 128;
  localparam int unsigned SlotW = $clog2(MaxTimeouts);
  localparam int unsigned CntW = SlotW + 1;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_POP      = 2'd2,
    CMD_REINSERT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADREIN  = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] etime;
    logic [63:0] period;
    logic [5:0]  client;
    logic [6:0]  id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RD2,
    S_DN_CMP,
    S_HEAD_RD,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/tmhq_store.sv =====
// Heap entry memory with one write port and two registered read ports.
module tmhq_store import tmhq_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [SlotW-1:0] raddr_a_i,
  input  logic [SlotW-1:0] raddr_b_i,
  output entry_t           rdata_a_o,
  output entry_t           rdata_b_o
);

  entry_t mem_q [MaxTimeouts];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/timeout_min_heap_queue_top.sv =====
// Top level of the timeout min-heap queue: sequencer, id bitmap and sift logic.
//
//  channel | direction | handshake          | payload
//  command | in        | start_i / busy_o   | command_i, expiry_time_i, repeat_period_i,
//          |           |                    | client_channel_i, entry_id_i
//  result  | out       | done_o (one cycle) | ok_o, status_o, result_id_o, popped_*_o,
//          |           |                    | head_valid_o, head_time_o, entry_count_o
//
// A command is taken when start_i is high and busy_o low; busy_o stays high
// through the result strobe. Delete and reinsert walk the live slots one per
// cycle through the entry memory; each sift level then compares on the shared
// 64-bit comparator, going up through S_UP_RD and S_UP_CMP and down through
// S_DN_RD, S_DN_RD2 and S_DN_CMP, 7 levels at most. Reset clears the id bitmap
// and the count; the entry memory is not cleared. The receiver cannot stall.
module timeout_min_heap_queue_top import tmhq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] expiry_time_i,
  input  logic [63:0] repeat_period_i,
  input  logic [5:0]  client_channel_i,
  input  logic [6:0]  entry_id_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [2:0]  status_o,
  output logic [6:0]  result_id_o,
  output logic [63:0] popped_time_o,
  output logic [63:0] popped_period_o,
  output logic [5:0]  popped_client_o,
  output logic        head_valid_o,
  output logic [63:0] head_time_o,
  output logic [7:0]  entry_count_o
);

  state_e state_q, state_d;
  logic [MaxTimeouts-1:0] used_q, used_d;
  logic [CntW-1:0] size_q, size_d;
  cmd_e cmd_q, cmd_d;
  entry_t in_q, in_d;         // command operands, later the moving entry
  logic [CntW-1:0] idx_q, idx_d;   // scan index or sift position
  logic [CntW-1:0] slot_q, slot_d; // found slot, later the chosen child
  logic found_q, found_d;
  logic moved_up_q, moved_up_d;
  status_e st_q, st_d;
  logic [6:0] rid_q, rid_d;
  entry_t pop_q, pop_d;
  entry_t cur_q, cur_d;       // entry held at sift position
  logic [63:0] head_q, head_d;
  logic done_q, done_d;

  logic we;
  logic [SlotW-1:0] waddr, ra, rb;
  entry_t wdata, rda, rdb;

  tmhq_store u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra),
    .raddr_b_i(rb),
    .rdata_a_o(rda),
    .rdata_b_o(rdb)
  );

  // Lowest free id: priority encoder over the bitmap.
  logic [SlotW-1:0] free_id;
  logic free_any;
  always_comb begin
    free_id = '0;
    free_any = 1'b0;
    for (int k = MaxTimeouts - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        free_id = SlotW'(k);
        free_any = 1'b1;
      end
    end
  end

  // Shared comparator: strictly less than.
  logic [63:0] cmp_a, cmp_b;
  logic cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic [CntW-1:0] parent, lchild, rchild;
  assign parent = (idx_q - CntW'(1)) >> 1;
  assign lchild = {idx_q[CntW-2:0], 1'b1};
  assign rchild = lchild + CntW'(1);

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    size_d = size_q;
    cmd_d = cmd_q;
    in_d = in_q;
    idx_d = idx_q;
    slot_d = slot_q;
    found_d = found_q;
    moved_up_d = moved_up_q;
    st_d = st_q;
    rid_d = rid_q;
    pop_d = pop_q;
    cur_d = cur_q;
    head_d = head_q;
    done_d = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = in_q;
    ra = '0;
    rb = '0;
    cmp_a = cur_q.etime;
    cmp_b = rda.etime;
    case (state_q)
      S_IDLE: begin
        if (start_i && !done_q) begin
          cmd_d = cmd_e'(command_i);
          in_d.etime = expiry_time_i;
          in_d.period = repeat_period_i;
          in_d.client = client_channel_i;
          in_d.id = entry_id_i;
          st_d = ST_OK;
          rid_d = '0;
          pop_d = '0;
          idx_d = '0;
          found_d = 1'b0;
          moved_up_d = 1'b0;
          state_d = S_DECIDE;
          if (cmd_e'(command_i) == CMD_DELETE || cmd_e'(command_i) == CMD_REINSERT) begin
            state_d = (size_q == '0) ? S_DECIDE : S_SCAN;
          end
          if (cmd_e'(command_i) == CMD_POP) begin
            state_d = S_SCAN_WAIT; // read slot 0
          end
        end
      end
      // Walk live slots looking for the id; the read data is registered.
      S_SCAN: begin
        ra = idx_q[SlotW-1:0];
        state_d = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (cmd_q == CMD_POP) begin
          pop_d = rda;
          state_d = S_DECIDE;
        end else begin
          if (rda.id == in_q.id) begin
            found_d = 1'b1;
            slot_d = idx_q;
            cur_d = rda;
            state_d = S_DECIDE;
          end else if (idx_q + CntW'(1) >= size_q) begin
            state_d = S_DECIDE;
          end else begin
            idx_d = idx_q + CntW'(1);
            ra = idx_d[SlotW-1:0];
            state_d = S_SCAN_WAIT;
          end
        end
      end
      S_DECIDE: begin
        state_d = S_HEAD_RD;
        case (cmd_q)
          CMD_INSERT: begin
            if (size_q >= CntW'(MaxTimeouts) || !free_any) begin
              st_d = ST_FULL;
            end else begin
              used_d[free_id] = 1'b1;
              rid_d = 7'(free_id);
              in_d.id = 7'(free_id);
              cur_d = in_q;
              cur_d.id = 7'(free_id);
              idx_d = size_q;
              size_d = size_q + CntW'(1);
              state_d = S_UP_RD;
            end
          end
          CMD_REINSERT: begin
            if (CntW'(in_q.id) >= CntW'(MaxTimeouts) || !used_q[in_q.id[SlotW-1:0]] ||
                in_q.period == '0 || found_q) begin
              st_d = ST_BADREIN;
            end else if (size_q >= CntW'(MaxTimeouts)) begin
              st_d = ST_FULL;
            end else begin
              rid_d = in_q.id;
              cur_d = in_q;
              cur_d.etime = in_q.etime + in_q.period;
              idx_d = size_q;
              size_d = size_q + CntW'(1);
              state_d = S_UP_RD;
            end
          end
          CMD_DELETE: begin
            if (!found_q || cur_q.client != in_q.client) begin
              st_d = ST_NOTFOUND;
            end else begin
              used_d[cur_q.id[SlotW-1:0]] = 1'b0;
              size_d = size_q - CntW'(1);
              idx_d = slot_q;
              state_d = (slot_q == size_q - CntW'(1)) ? S_HEAD_RD : S_MOVE_RD;
            end
          end
          default: begin // pop
            if (size_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              rid_d = pop_q.id;
              if (pop_q.period == '0) begin
                used_d[pop_q.id[SlotW-1:0]] = 1'b0;
              end
              size_d = size_q - CntW'(1);
              idx_d = '0;
              state_d = (size_q == CntW'(1)) ? S_HEAD_RD : S_MOVE_RD;
            end
          end
        endcase
      end
      // Fetch the last entry that fills the hole.
      S_MOVE_RD: begin
        ra = size_q[SlotW-1:0];
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cur_d = rda;
        if (cmd_q == CMD_DELETE && idx_q != '0) begin
          state_d = S_UP_RD;
          moved_up_d = 1'b0;
        end else begin
          state_d = S_DN_RD;
        end
      end
      // Sift up: cur_q is the entry headed for position idx_q.
      S_UP_RD: begin
        if (idx_q == '0) begin
          we = 1'b1;
          waddr = idx_q[SlotW-1:0];
          wdata = cur_q;
          state_d = S_HEAD_RD;
        end else begin
          ra = parent[SlotW-1:0];
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        waddr = idx_q[SlotW-1:0];
        if (cmp_lt) begin
          wdata = rda;
          idx_d = parent;
          moved_up_d = 1'b1;
          state_d = S_UP_RD;
        end else begin
          wdata = cur_q;
          // Delete whose entry stayed put continues downward.
          state_d = (cmd_q == CMD_DELETE && !moved_up_q) ? S_DN_RD : S_HEAD_RD;
        end
      end
      // Sift down: read both children.
      S_DN_RD: begin
        if (lchild >= size_q) begin
          we = 1'b1;
          waddr = idx_q[SlotW-1:0];
          wdata = cur_q;
          state_d = S_HEAD_RD;
        end else begin
          ra = lchild[SlotW-1:0];
          rb = rchild[SlotW-1:0];
          state_d = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        // Pick the smaller child; right wins only when strictly smaller.
        cmp_a = rdb.etime;
        cmp_b = rda.etime;
        if (rchild < size_q && cmp_lt) begin
          pop_d = pop_q;
          slot_d = rchild;
          in_d = rdb;
        end else begin
          slot_d = lchild;
          in_d = rda;
        end
        // keep command operand id not needed past decide
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_a = in_q.etime;
        cmp_b = cur_q.etime;
        we = 1'b1;
        waddr = idx_q[SlotW-1:0];
        if (cmp_lt) begin
          wdata = in_q;
          idx_d = slot_q;
          state_d = S_DN_RD;
        end else begin
          wdata = cur_q;
          state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        ra = '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        head_d = (size_q == '0) ? '0 : rda.etime;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      size_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      size_q <= size_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    in_q <= in_d;
    idx_q <= idx_d;
    slot_q <= slot_d;
    found_q <= found_d;
    moved_up_q <= moved_up_d;
    st_q <= st_d;
    rid_q <= rid_d;
    pop_q <= pop_d;
    cur_q <= cur_d;
    head_q <= head_d;
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign ok_o = (st_q == ST_OK);
  assign status_o = st_q;
  assign result_id_o = rid_q;
  assign popped_time_o = (st_q == ST_OK) ? pop_q.etime : '0;
  assign popped_period_o = (st_q == ST_OK) ? pop_q.period : '0;
  assign popped_client_o = (st_q == ST_OK) ? pop_q.client : '0;
  assign head_valid_o = (size_q != '0);
  assign head_time_o = head_q;
  assign entry_count_o = 8'(size_q);

  // Count never exceeds capacity.
  a_size_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CntW'(MaxTimeouts)) else $error("heap count over capacity");
  // Strobe is a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  // A failed command leaves the count unchanged.
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && st_d != ST_OK) |=> $stable(size_q))
    else $error("count changed on failed command");

endmodule

// ===== bench/testbench.sv =====
// Testbench for the timeout min-heap queue: directed and random commands checked against a heap predictor.
`timescale 1ns / 100ps

module testbench;
  import tmhq_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] etime;
    logic [63:0] period;
    logic [5:0]  client;
    logic [6:0]  id;
    bit          hold;   // pause until every expected word has arrived
  } cmd_word_t;

  typedef struct {
    logic        ok;
    status_e     status;
    logic [6:0]  rid;
    logic [63:0] ptime;
    logic [63:0] pperiod;
    logic [5:0]  pclient;
    logic        hvalid;
    logic [63:0] htime;
    logic [7:0]  count;
  } resp_t;

  localparam int unsigned CycleLimit = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = '0;
  logic [63:0] expiry_time_i = '0;
  logic [63:0] repeat_period_i = '0;
  logic [5:0]  client_channel_i = '0;
  logic [6:0]  entry_id_i = '0;
  logic        done_o, ok_o, head_valid_o;
  logic [2:0]  status_o;
  logic [6:0]  result_id_o;
  logic [63:0] popped_time_o, popped_period_o, head_time_o;
  logic [5:0]  popped_client_o;
  logic [7:0]  entry_count_o;

  timeout_min_heap_queue_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap, mirrors the block's state after every accepted word.
  entry_t      shadow_heap [MaxTimeouts];
  bit          shadow_used [MaxTimeouts];
  int unsigned shadow_size;

  cmd_word_t   pending_cmds[$];
  resp_t       expected_resps[$];
  int unsigned errors;
  int unsigned cycles;
  bit          stim_done;
  bit          idle_free;   // long stretch with no idling

  // Simple helpers used by the stimulus to aim at live ids.
  int unsigned heap_model_size;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic int unsigned sift_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (shadow_heap[i].etime >= shadow_heap[p].etime) break;
      swap_slots(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void sift_down(int unsigned i);
    int unsigned l, r, m;
    while (i < shadow_size) begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l >= shadow_size) break;
      if (shadow_heap[l].etime < shadow_heap[m].etime) m = l;
      if (r < shadow_size && shadow_heap[r].etime < shadow_heap[m].etime) m = r;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  function automatic void push_entry(logic [63:0] t, logic [63:0] p, logic [5:0] c,
                                     logic [6:0] id);
    shadow_heap[shadow_size] = '{etime: t, period: p, client: c, id: id};
    shadow_size++;
    void'(sift_up(shadow_size - 1));
  endfunction

  function automatic int find_live(logic [6:0] id);
    for (int i = 0; i < shadow_size; i++)
      if (shadow_heap[i].id == id) return i;
    return -1;
  endfunction

  // Apply one command to the shadow heap and return the word the block should give.
  function automatic resp_t predict_timeout_result(cmd_word_t w);
    resp_t r;
    int    slot;
    int    free_id;
    int unsigned last;
    r = '{ok: 1'b0, status: ST_OK, rid: '0, ptime: '0, pperiod: '0, pclient: '0,
          hvalid: 1'b0, htime: '0, count: '0};
    case (w.cmd)
      CMD_INSERT: begin
        free_id = -1;
        if (shadow_size < MaxTimeouts)
          for (int i = 0; i < MaxTimeouts; i++)
            if (!shadow_used[i]) begin
              free_id = i;
              break;
            end
        if (free_id < 0) r.status = ST_FULL;
        else begin
          shadow_used[free_id] = 1'b1;
          push_entry(w.etime, w.period, w.client, 7'(free_id));
          r.rid = 7'(free_id);
        end
      end
      CMD_DELETE: begin
        slot = find_live(w.id);
        if (slot < 0 || shadow_heap[slot].client != w.client) r.status = ST_NOTFOUND;
        else begin
          last = shadow_size - 1;
          shadow_used[shadow_heap[slot].id] = 1'b0;
          if (slot != last) swap_slots(slot, last);
          shadow_size = last;
          if (slot < shadow_size)
            if (sift_up(slot) == slot) sift_down(slot);
        end
      end
      CMD_POP: begin
        if (shadow_size == 0) r.status = ST_EMPTY;
        else begin
          last = shadow_size - 1;
          r.rid = shadow_heap[0].id;
          r.ptime = shadow_heap[0].etime;
          r.pperiod = shadow_heap[0].period;
          r.pclient = shadow_heap[0].client;
          if (r.pperiod == 0) shadow_used[r.rid] = 1'b0;
          if (last != 0) swap_slots(0, last);
          shadow_size = last;
          sift_down(0);
        end
      end
      default: begin
        if (!shadow_used[w.id] || w.period == 0 || find_live(w.id) >= 0)
          r.status = ST_BADREIN;
        else if (shadow_size >= MaxTimeouts) r.status = ST_FULL;
        else begin
          push_entry(w.etime + w.period, w.period, w.client, w.id);
          r.rid = w.id;
        end
      end
    endcase
    r.ok = (r.status == ST_OK);
    r.hvalid = (shadow_size != 0);
    r.htime = (shadow_size != 0) ? shadow_heap[0].etime : '0;
    r.count = 8'(shadow_size);
    return r;
  endfunction

  // Stimulus-side tracking of which ids are live or reserved (separate from the predictor).
  bit          gen_live [MaxTimeouts];
  bit          gen_rsvd [MaxTimeouts];
  logic [5:0]  gen_client [MaxTimeouts];

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'(($urandom_range(0, 1)) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff);
      3: v = 64'($urandom_range(0, 40));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [6:0] pick_id(bit want_rsvd);
    int tries;
    logic [6:0] id;
    for (tries = 0; tries < 40; tries++) begin
      id = 7'($urandom_range(0, MaxTimeouts - 1));
      if (want_rsvd ? gen_rsvd[id] : gen_live[id]) return id;
    end
    return 7'($urandom_range(0, MaxTimeouts - 1));
  endfunction

  // Queue one word; rough tracking of ids keeps deletes and reinserts well-formed.
  task automatic add_cmd(cmd_e c, logic [63:0] t, logic [63:0] p, logic [5:0] cl,
                         logic [6:0] id, bit hold);
    pending_cmds.push_back('{cmd: c, etime: t, period: p, client: cl, id: id, hold: hold});
  endtask

  task automatic add_random_cmd();
    int sel;
    logic [6:0] id;
    logic [5:0] cl;
    sel = $urandom_range(0, 99);
    cl = 6'($urandom);
    if (sel < 35) begin
      add_cmd(CMD_INSERT, rand64(), ($urandom_range(0, 2) == 0) ? 64'd0 : rand64(), cl,
              7'($urandom), 1'b0);
    end else if (sel < 55) begin
      id = pick_id(1'b0);
      if ($urandom_range(0, 4) != 0 && gen_live[id]) cl = gen_client[id];
      add_cmd(CMD_DELETE, rand64(), rand64(), cl, id, 1'b0);
    end else if (sel < 80) begin
      add_cmd(CMD_POP, rand64(), rand64(), cl, 7'($urandom), 1'b0);
    end else begin
      id = pick_id(1'b1);
      add_cmd(CMD_REINSERT, rand64(), ($urandom_range(0, 9) == 0) ? 64'd0 : rand64(),
              gen_client[id], id, 1'b0);
    end
  endtask

  // Generator-side tracking: replay the word through a private predictor copy is
  // not possible before acceptance, so update the coarse id view optimistically.
  function automatic void track_cmd(cmd_word_t w, resp_t r);
    if (!r.ok) return;
    case (w.cmd)
      CMD_INSERT, CMD_REINSERT: begin
        gen_live[r.rid] = 1'b1;
        gen_rsvd[r.rid] = 1'b0;
        gen_client[r.rid] = w.client;
      end
      CMD_DELETE: gen_live[w.id] = 1'b0;
      default: begin
        gen_live[r.rid] = 1'b0;
        gen_rsvd[r.rid] = (r.pperiod != 0);
        gen_client[r.rid] = r.pclient;
      end
    endcase
  endfunction

  // Driver: present the oldest pending word, drop it on acceptance.
  bit accepted;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (accepted) begin
        cmd_word_t w;
        resp_t r;
        w = pending_cmds.pop_front();
        r = predict_timeout_result(w);
        track_cmd(w, r);
        expected_resps.push_back(r);
      end
      if (pending_cmds.size() != 0 && !(accepted || (start_i && busy_o) ? 1'b0 : 1'b0)) begin
        if (start_i && !accepted) begin
          // hold the current word until it is taken
        end else if (pending_cmds[0].hold && expected_resps.size() != 0) begin
          start_i <= 1'b0;
        end else if (!idle_free && $urandom_range(0, 99) < 25) begin
          start_i <= 1'b0;
        end else begin
          start_i          <= 1'b1;
          command_i        <= pending_cmds[0].cmd;
          expiry_time_i    <= pending_cmds[0].etime;
          repeat_period_i  <= pending_cmds[0].period;
          client_channel_i <= pending_cmds[0].client;
          entry_id_i       <= pending_cmds[0].id;
        end
      end else if (!(start_i && !accepted)) begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result word, status %0d", $time, status_o);
        errors++;
      end else begin
        resp_t e;
        e = expected_resps.pop_front();
        if ({ok_o, status_o, result_id_o, popped_time_o, popped_period_o, popped_client_o,
             head_valid_o, head_time_o, entry_count_o} !==
            {e.ok, e.status, e.rid, e.ptime, e.pperiod, e.pclient, e.hvalid, e.htime,
             e.count}) begin
          $display("%0t: expected ok %0b st %0d id %0d pt %h pp %h pc %0d hv %0b ht %h n %0d",
                   $time, e.ok, e.status, e.rid, e.ptime, e.pperiod, e.pclient, e.hvalid,
                   e.htime, e.count);
          $display("%0t: actual   ok %0b st %0d id %0d pt %h pp %h pc %0d hv %0b ht %h n %0d",
                   $time, ok_o, status_o, result_id_o, popped_time_o, popped_period_o,
                   popped_client_o, head_valid_o, head_time_o, entry_count_o);
          errors++;
        end
      end
    end
  end

  // Cycle limit: end the run if the block stops answering.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout_min_heap_queue_top: mismatch");
      $finish;
    end
  end

  // Wait until the driver has drained its queue and nothing is owed.
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_resps.size() != 0 || start_i)
      @(posedge clk_i);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_free = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, extremes, equal times, full heap, every error status.
    add_cmd(CMD_POP, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_DELETE, '0, '0, '0, 7'd0, 1'b0);
    add_cmd(CMD_REINSERT, '1, 64'd5, 6'd3, 7'd127, 1'b0);
    add_cmd(CMD_INSERT, '1, '1, 6'd63, 7'd127, 1'b0);
    add_cmd(CMD_INSERT, 64'd0, 64'd0, 6'd0, 7'd0, 1'b0);
    add_cmd(CMD_INSERT, 64'd7, 64'd10, 6'd1, 7'd0, 1'b0);
    add_cmd(CMD_INSERT, 64'd7, 64'd0, 6'd2, 7'd0, 1'b0);
    add_cmd(CMD_DELETE, '0, '0, 6'd5, 7'd2, 1'b0);     // wrong client
    add_cmd(CMD_DELETE, '0, '0, 6'd2, 7'd3, 1'b0);
    add_cmd(CMD_POP, '0, '0, '0, '0, 1'b0);
    add_cmd(CMD_POP, '0, '0, '0, '0, 1'b0);            // periodic id 2 reserved
    add_cmd(CMD_REINSERT, 64'd7, 64'd0, 6'd1, 7'd2, 1'b0);  // zero period
    add_cmd(CMD_REINSERT, '1, 64'd10, 6'd1, 7'd2, 1'b0);    // wraps
    add_cmd(CMD_REINSERT, 64'd7, 64'd10, 6'd1, 7'd2, 1'b0); // already live
    add_cmd(CMD_DELETE, '0, '0, 6'd63, 7'd0, 1'b0);
    for (int i = 0; i < 130; i++)
      add_cmd(CMD_INSERT, 64'($urandom_range(0, 3)), 64'(i % 2), 6'(i), '0, 1'b0);
    add_cmd(CMD_REINSERT, 64'd1, 64'd1, 6'd0, 7'd2, 1'b1);
    for (int i = 0; i < 132; i++)
      add_cmd(CMD_POP, '0, '0, '0, '0, 1'b0);
    drain();

    // Random: track ids coarsely from the predictor after each drain.
    for (int n = 0; n < 420; n++) begin
      if (n == 200) idle_free = 1'b1;
      if (n == 350) idle_free = 1'b0;
      if (n % 25 == 0) begin
        drain();
        for (int i = 0; i < MaxTimeouts; i++) begin
          gen_live[i] = (find_live(7'(i)) >= 0);
          gen_rsvd[i] = shadow_used[i] && !gen_live[i];
        end
        for (int i = 0; i < shadow_size; i++)
          gen_client[shadow_heap[i].id] = shadow_heap[i].client;
      end
      add_random_cmd();
    end
    pending_cmds[$].hold = 1'b1;
    drain();
    repeat (300) @(posedge clk_i);

    if (errors == 0 && expected_resps.size() == 0)
      $display("timeout_min_heap_queue_top: match");
    else
      $display("timeout_min_heap_queue_top: mismatch");
    $finish;
  end

endmodule
